// ===== hdl/ilid_pkg.sv =====
// Package for the indexed list block: capacity, derived widths, request and
// status codes, and the control bundle broadcast to the row of entry cells.
// No dependencies.
`default_nettype none

package ilid_pkg;

   localparam int CAPACITY = 64;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int CMP_W    = (CNT_W > 7) ? CNT_W : 7;
   localparam int DATA_W   = 32;
   localparam int OUT_CNT_W = 7;

   typedef enum logic [2:0] {
      REQ_READ       = 3'd0,
      REQ_INSERT_HEAD = 3'd1,
      REQ_APPEND_TAIL = 3'd2,
      REQ_INSERT_AT  = 3'd3,
      REQ_DELETE_AT  = 3'd4
   } req_code_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // Broadcast to every cell in the cycle a request is transferred.
   typedef struct packed {
      logic              ins;
      logic              del;
      logic              rd;
      logic [CNT_W-1:0]  at;
      logic [CNT_W-1:0]  len;
      logic [DATA_W-1:0] val;
   } cell_ctrl_type;

endpackage

`default_nettype wire

// ===== hdl/indexed_list_insert_delete.sv =====
// Top level of the indexed list: request decode, length register, the row of
// entry cells and the response register. Uses ilid_pkg and ilid_cell.
`default_nettype none

// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_ready  req_type, req_position, req_item_value
// rsp       out        rsp_valid / rsp_ready  rsp_status, rsp_read_value, rsp_entry_count
//
// The whole row of cells shifts in parallel at the edge that transfers a request,
// and the response is registered there. A new request is taken in each cycle
// the response register is empty or is being drained, so the block sustains
// one transfer per cycle. Reset clears the length and the response valid; cell
// contents stay undefined until written.

module indexed_list_insert_delete (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [2:0]  req_type,
   input  wire logic signed [7:0]  req_position,
   input  wire logic signed [31:0] req_item_value,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_status,
   output logic signed [31:0] rsp_read_value,
   output logic [6:0]       rsp_entry_count
);

   localparam int N = ilid_pkg::CAPACITY;
   localparam int W = ilid_pkg::DATA_W;

   logic [ilid_pkg::CNT_W-1:0] length_ff, length_in;
   logic                       rsp_valid_ff;
   ilid_pkg::status_type       status_ff, status_in;
   logic [W-1:0]               read_value_ff, read_value_in;
   logic [ilid_pkg::OUT_CNT_W-1:0] count_ff;

   logic                       accept;
   logic                       neg;
   logic [ilid_pkg::CMP_W-1:0] pos_c, len_c, len_next_c;
   logic                       full;
   ilid_pkg::cell_ctrl_type    ctrl;

   logic [W-1:0] cell_data [N];
   logic [W-1:0] cell_read [N];
   logic [W-1:0] read_or;

   // The response register frees itself when its content is taken, so a new
   // request may be transferred in the same cycle.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign neg   = req_position[7];
   assign pos_c = ilid_pkg::CMP_W'(req_position[6:0]);
   assign len_c = ilid_pkg::CMP_W'(length_ff);
   assign full  = (length_ff == ilid_pkg::CNT_W'(N));

   // Request decode. Cell controls only take effect on a transferred request.
   always_comb begin
      ctrl      = '0;
      ctrl.len  = length_ff;
      ctrl.val  = req_item_value;
      status_in = ilid_pkg::ST_DONE;
      length_in = length_ff;
      unique case (req_type)
         ilid_pkg::REQ_READ: begin
            if (neg || pos_c >= len_c) begin
               status_in = ilid_pkg::ST_RANGE;
            end else begin
               ctrl.rd = accept;
               ctrl.at = ilid_pkg::CNT_W'(pos_c);
            end
         end
         ilid_pkg::REQ_INSERT_HEAD,
         ilid_pkg::REQ_APPEND_TAIL: begin
            if (full) begin
               status_in = ilid_pkg::ST_FULL;
            end else begin
               ctrl.ins  = accept;
               ctrl.at   = (req_type == ilid_pkg::REQ_INSERT_HEAD) ? '0 : length_ff;
               length_in = length_ff + ilid_pkg::CNT_W'(1);
            end
         end
         ilid_pkg::REQ_INSERT_AT: begin
            // The range check comes before the full check.
            if (neg || pos_c > len_c) begin
               status_in = ilid_pkg::ST_RANGE;
            end else if (full) begin
               status_in = ilid_pkg::ST_FULL;
            end else begin
               ctrl.ins  = accept;
               ctrl.at   = ilid_pkg::CNT_W'(pos_c);
               length_in = length_ff + ilid_pkg::CNT_W'(1);
            end
         end
         ilid_pkg::REQ_DELETE_AT: begin
            if (neg || pos_c >= len_c) begin
               status_in = ilid_pkg::ST_RANGE;
            end else begin
               ctrl.del  = accept;
               ctrl.at   = ilid_pkg::CNT_W'(pos_c);
               length_in = length_ff - ilid_pkg::CNT_W'(1);
            end
         end
         default: begin
            status_in = ilid_pkg::ST_RANGE;
         end
      endcase
   end

   // The row of cells. Each cell sees its neighbors' stored values; the ends
   // see zero, which the shift conditions never select.
   for (genvar i = 0; i < N; i++) begin : g_cell
      logic [W-1:0] prev_d, next_d;
      if (i == 0) begin : g_first
         assign prev_d = '0;
      end else begin : g_mid_prev
         assign prev_d = cell_data[i-1];
      end
      if (i == N - 1) begin : g_last
         assign next_d = '0;
      end else begin : g_mid_next
         assign next_d = cell_data[i+1];
      end
      ilid_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .cell_index (ilid_pkg::CNT_W'(i)),
         .prev_data  (prev_d),
         .next_data  (next_d),
         .data       (cell_data[i]),
         .read_data  (cell_read[i])
      );
   end

   // Only the addressed cell drives a nonzero read word, so an OR collects it.
   always_comb begin
      read_or = '0;
      for (int k = 0; k < N; k++) begin
         read_or = read_or | cell_read[k];
      end
   end

   always_comb begin
      if (req_type == ilid_pkg::REQ_READ && status_in == ilid_pkg::ST_RANGE) begin
         read_value_in = '1;
      end else begin
         read_value_in = read_or;
      end
   end

   assign len_next_c = ilid_pkg::CMP_W'(length_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            length_ff    <= length_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff     <= status_in;
         read_value_ff <= read_value_in;
         count_ff      <= len_next_c[ilid_pkg::OUT_CNT_W-1:0];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_read_value  = read_value_ff;
   assign rsp_entry_count = count_ff;

endmodule

`default_nettype wire

// ===== hdl/ilid_cell.sv =====
// One entry cell of the indexed list: holds a single value and takes it from
// the request, from its lower neighbor or from its upper neighbor. Uses ilid_pkg.
`default_nettype none

module ilid_cell (
   input  wire logic                          clock,
   input  wire ilid_pkg::cell_ctrl_type       ctrl,
   input  wire logic [ilid_pkg::CNT_W-1:0]    cell_index,
   input  wire logic [ilid_pkg::DATA_W-1:0]   prev_data,
   input  wire logic [ilid_pkg::DATA_W-1:0]   next_data,
   output logic      [ilid_pkg::DATA_W-1:0]   data,
   output logic      [ilid_pkg::DATA_W-1:0]   read_data
);

   logic [ilid_pkg::DATA_W-1:0] data_ff;
   logic [ilid_pkg::DATA_W-1:0] data_in;
   logic [ilid_pkg::CNT_W-1:0]  index_plus1;

   assign index_plus1 = cell_index + ilid_pkg::CNT_W'(1);

   always_comb begin
      data_in = data_ff;
      if (ctrl.ins) begin
         if (cell_index == ctrl.at) begin
            data_in = ctrl.val;
         end else if (cell_index > ctrl.at && cell_index <= ctrl.len) begin
            data_in = prev_data;
         end
      end else if (ctrl.del) begin
         if (cell_index >= ctrl.at && index_plus1 < ctrl.len) begin
            data_in = next_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data      = data_ff;
   assign read_data = (ctrl.rd && cell_index == ctrl.at) ? data_ff : '0;

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// Self-checking testbench for indexed_list_insert_delete: a queue-fed driver,
// a response monitor and an in-testbench prediction of the bounded list.
// Depends on ilid_pkg and the indexed_list_insert_delete RTL.
`timescale 1ns / 100ps

module tb_top;

   // About this many random requests that the block acts on. Unknown request
   // codes do not count toward it.
   localparam int RANDOM_ITEMS = 1825;
   // Cycles without any transfer on either channel before the run is abandoned.
   localparam int STALL_LIMIT  = 4000;
   // Quiet cycles at the end, so that a stray response still gets caught.
   localparam int TAIL_CYCLES  = 20;

   typedef struct {
      logic [2:0]         kind;
      logic signed [7:0]  pos;
      logic signed [31:0] value;
      bit                 hold;   // wait for every outstanding response first
   } list_req_type;

   typedef struct {
      ilid_pkg::status_type status;
      logic signed [31:0]   rd;
      logic [6:0]           count;
   } list_rsp_type;

   // Request mixes for the random part.
   typedef enum {MIX_FILL, MIX_DRAIN, MIX_ANY, MIX_NOISE} op_mix_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [2:0]          req_type = ilid_pkg::REQ_READ;
   logic signed [7:0]   req_position = '0;
   logic signed [31:0]  req_item_value = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [1:0]          rsp_status;
   logic signed [31:0]  rsp_read_value;
   logic [6:0]          rsp_entry_count;

   // Requests waiting to be offered, and responses predicted but not yet seen.
   list_req_type req_backlog[$];
   list_rsp_type list_rsp_due[$];

   // Predicted list contents and length, advanced at each request transfer.
   logic signed [31:0] list_mem [ilid_pkg::CAPACITY];
   int                 list_len = 0;

   // Length as seen while the stimulus is built, used to aim positions.
   int gen_len = 0;

   // Transfer counters. The driver owns n_predicted and the monitor owns
   // n_checked; both are updated with nonblocking assignments so that each
   // side reads the other's value from before the edge.
   int n_predicted = 0;
   int n_checked   = 0;
   int phase_len   = 1;
   int err_count   = 0;
   int stall_cycles = 0;

   indexed_list_insert_delete DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_position    (req_position),
      .req_item_value  (req_item_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_read_value  (rsp_read_value),
      .rsp_entry_count (rsp_entry_count)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Applies one request to the predicted list and returns the response the
   // block must give for it. Inserts share one path once the target slot is
   // known; a range error on insert-at-position wins over the full check.
   function automatic list_rsp_type apply_list_op(list_req_type r);
      list_rsp_type o;
      int           p;
      int           slot;
      p        = r.pos;
      slot     = -1;
      o.status = ilid_pkg::ST_DONE;
      o.rd     = '0;
      case (r.kind)
         ilid_pkg::REQ_READ: begin
            if (p < 0 || p >= list_len) begin
               o.status = ilid_pkg::ST_RANGE;
               o.rd     = '1;
            end else begin
               o.rd = list_mem[p];
            end
         end
         ilid_pkg::REQ_INSERT_HEAD: slot = 0;
         ilid_pkg::REQ_APPEND_TAIL: slot = list_len;
         ilid_pkg::REQ_INSERT_AT: begin
            if (p < 0 || p > list_len) begin
               o.status = ilid_pkg::ST_RANGE;
            end else begin
               slot = p;
            end
         end
         ilid_pkg::REQ_DELETE_AT: begin
            if (p < 0 || p >= list_len) begin
               o.status = ilid_pkg::ST_RANGE;
            end else begin
               for (int i = p; i + 1 < list_len; i++) list_mem[i] = list_mem[i + 1];
               list_len--;
            end
         end
         default: o.status = ilid_pkg::ST_RANGE;   // unknown codes leave the list alone
      endcase
      if (slot >= 0) begin
         if (list_len >= ilid_pkg::CAPACITY) begin
            o.status = ilid_pkg::ST_FULL;
         end else begin
            for (int i = list_len; i > slot; i--) list_mem[i] = list_mem[i - 1];
            list_mem[slot] = r.value;
            list_len++;
         end
      end
      o.count = 7'(list_len);
      return o;
   endfunction

   // Queues one request and tracks the length it leaves behind, so that later
   // positions can be aimed at the valid range and its edges.
   function automatic void add_req(logic [2:0] kind, logic signed [7:0] pos,
                                   logic signed [31:0] value, bit hold);
      list_req_type r;
      int           p;
      r.kind  = kind;
      r.pos   = pos;
      r.value = value;
      r.hold  = hold;
      req_backlog.push_back(r);
      p = pos;
      case (kind)
         ilid_pkg::REQ_INSERT_HEAD, ilid_pkg::REQ_APPEND_TAIL: begin
            if (gen_len < ilid_pkg::CAPACITY) gen_len++;
         end
         ilid_pkg::REQ_INSERT_AT: begin
            if (p >= 0 && p <= gen_len && gen_len < ilid_pkg::CAPACITY) gen_len++;
         end
         ilid_pkg::REQ_DELETE_AT: begin
            if (p >= 0 && p < gen_len) gen_len--;
         end
         default: ;
      endcase
   endfunction

   // A position in 0..top most of the time, weighted toward both ends, and
   // otherwise one above the range, up to 127, or a negative one.
   function automatic logic signed [7:0] choose_pos(int top);
      int r;
      r = $urandom_range(99);
      if (top >= 0 && r < 88) begin
         if (r < 15) return 8'sd0;
         if (r < 30) return 8'(top);
         return 8'($urandom_range(top));
      end
      if (top < 127 && r[0]) return 8'($urandom_range(127, top + 1));
      return 8'(-int'($urandom_range(128, 1)));
   endfunction

   // Builds one random request of the given mix. Returns 1 when the request
   // carries a known code, so that it counts toward the random total.
   function automatic bit gen_op(op_mix_type mix);
      logic [2:0]         kind;
      logic signed [7:0]  pos;
      logic signed [31:0] value;
      int                 r;
      r = $urandom_range(99);
      case (mix)
         MIX_FILL: begin
            if (r < 20) begin
               kind = ilid_pkg::REQ_READ;
            end else begin
               case ($urandom_range(2))
                  0:       kind = ilid_pkg::REQ_INSERT_HEAD;
                  1:       kind = ilid_pkg::REQ_APPEND_TAIL;
                  default: kind = ilid_pkg::REQ_INSERT_AT;
               endcase
            end
         end
         MIX_DRAIN: kind = (r < 25) ? ilid_pkg::REQ_READ : ilid_pkg::REQ_DELETE_AT;
         MIX_ANY:   kind = 3'($urandom_range(ilid_pkg::REQ_DELETE_AT));
         default:   kind = 3'($urandom);
      endcase
      case (kind)
         ilid_pkg::REQ_INSERT_AT: pos = choose_pos(gen_len);
         ilid_pkg::REQ_READ, ilid_pkg::REQ_DELETE_AT: pos = choose_pos(gen_len - 1);
         default:                 pos = 8'($urandom);
      endcase
      if (mix == MIX_NOISE) pos = 8'($urandom);
      case ($urandom_range(7))
         0:       value = 32'sh8000_0000;
         1:       value = 32'sh7FFF_FFFF;
         2:       value = '1;
         3:       value = '0;
         default: value = $urandom;
      endcase
      add_req(kind, pos, value, $urandom_range(149) == 0);
      return kind <= ilid_pkg::REQ_DELETE_AT;
   endfunction

   // Stimulus and end of test. The whole request list is built before the
   // clock starts; the driver then works through it at its own pace.
   initial begin
      int         n_rand;
      logic [2:0] odd_code;
      n_rand = 0;

      // Directed part: operations on the empty list, the value extremes,
      // insert at the tail position and just beyond it, reads at both ends of
      // the list and past it, the unknown codes, and deletes at both ends and
      // out of range. Insert head and append carry positions that must be
      // ignored.
      add_req(ilid_pkg::REQ_READ,        8'sd0,   32'sd0, 1'b0);
      add_req(ilid_pkg::REQ_DELETE_AT,   8'sd0,   32'sd0, 1'b0);
      add_req(ilid_pkg::REQ_READ,        -8'sd1,  32'sd0, 1'b0);
      add_req(ilid_pkg::REQ_INSERT_AT,   8'sd1,   32'sd9, 1'b0);
      add_req(ilid_pkg::REQ_INSERT_AT,   8'sd0,   32'sh7FFF_FFFF, 1'b0);
      add_req(ilid_pkg::REQ_INSERT_HEAD, 8'sh80,  32'sh8000_0000, 1'b0);
      add_req(ilid_pkg::REQ_APPEND_TAIL, 8'sd127, -32'sd1, 1'b0);
      add_req(ilid_pkg::REQ_APPEND_TAIL, 8'sd0,   32'sd0, 1'b0);
      add_req(ilid_pkg::REQ_INSERT_AT,   8'sd4,   32'sh5555_5555, 1'b0);
      add_req(ilid_pkg::REQ_INSERT_AT,   8'sd2,   32'shAAAA_AAAA, 1'b0);
      add_req(ilid_pkg::REQ_INSERT_AT,   8'sh80,  32'sd1, 1'b0);
      add_req(ilid_pkg::REQ_INSERT_AT,   8'sd7,   32'sd2, 1'b0);
      add_req(ilid_pkg::REQ_READ,        8'sd0,   32'sd0, 1'b0);
      add_req(ilid_pkg::REQ_READ,        8'sd5,   32'sd0, 1'b0);
      add_req(ilid_pkg::REQ_READ,        8'sd6,   32'sd0, 1'b0);
      add_req(ilid_pkg::REQ_READ,        8'sd127, 32'sd0, 1'b0);
      add_req(ilid_pkg::REQ_READ,        8'sh80,  32'sd0, 1'b0);
      odd_code = ilid_pkg::REQ_DELETE_AT;
      repeat (3) begin
         odd_code++;
         add_req(odd_code, 8'($urandom), $urandom, 1'b0);
      end
      add_req(ilid_pkg::REQ_DELETE_AT,   8'sd5,   32'sd0, 1'b0);
      add_req(ilid_pkg::REQ_DELETE_AT,   8'sd0,   32'sd0, 1'b0);
      add_req(ilid_pkg::REQ_DELETE_AT,   -8'sd1,  32'sd0, 1'b0);
      add_req(ilid_pkg::REQ_DELETE_AT,   8'sd127, 32'sd0, 1'b0);
      // This read waits until the list has answered everything before it.
      add_req(ilid_pkg::REQ_READ,        8'sd0,   32'sd0, 1'b1);

      // Random part, in bursts. Fill bursts run the list up to capacity and
      // then push a few more fill requests against the full list; drain bursts
      // empty it again and keep going for a few requests. Mixed bursts keep
      // positions mostly legal, and noise bursts randomize every field.
      while (n_rand < RANDOM_ITEMS) begin
         case ($urandom_range(9))
            0, 1, 2: begin
               while (gen_len < ilid_pkg::CAPACITY) n_rand += gen_op(MIX_FILL);
               repeat ($urandom_range(6, 1)) n_rand += gen_op(MIX_FILL);
            end
            3, 4: begin
               while (gen_len > 0) n_rand += gen_op(MIX_DRAIN);
               repeat ($urandom_range(4, 1)) n_rand += gen_op(MIX_DRAIN);
            end
            5, 6, 7, 8: repeat ($urandom_range(60, 10)) n_rand += gen_op(MIX_ANY);
            default: repeat ($urandom_range(12, 3)) n_rand += gen_op(MIX_NOISE);
         endcase
      end
      // The run is split into three equal stretches of idling behavior.
      phase_len = req_backlog.size() / 3;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (req_backlog.size() != 0 || n_checked != n_predicted) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (err_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Driver. A request is predicted at the edge that transfers it. A new one
   // is offered only when the channel is free, subject to the idle rate of
   // the current stretch; once offered it is held unchanged until taken.
   always @(posedge clock) begin : driver
      logic fire;
      int   issued;
      int   idle_pct;
      fire = req_valid && req_ready;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         issued = n_predicted;
         if (fire) begin
            list_rsp_due.push_back(apply_list_op(req_backlog[0]));
            req_backlog.pop_front();
            issued++;
            n_predicted <= issued;
         end
         if (!req_valid || fire) begin
            // Sender idle chance is 30 percent, then 87, then zero.
            idle_pct = (issued < phase_len) ? 30 : (issued < 2 * phase_len) ? 87 : 0;
            if (req_backlog.size() != 0 && $urandom_range(99) >= idle_pct &&
                !(req_backlog[0].hold && issued != n_checked)) begin
               req_valid      <= 1'b1;
               req_type       <= req_backlog[0].kind;
               req_position   <= req_backlog[0].pos;
               req_item_value <= req_backlog[0].value;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor. Every response transfer is checked against the oldest
   // prediction; one that arrives with nothing outstanding is an error.
   always @(posedge clock) begin : monitor
      list_rsp_type want;
      int           idle_pct;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (n_checked == n_predicted) begin
               $error("response with no request outstanding: status %0d value %0d count %0d",
                      rsp_status, rsp_read_value, rsp_entry_count);
               err_count++;
            end else begin
               want = list_rsp_due.pop_front();
               if (rsp_status !== want.status) begin
                  $error("rsp_status: expected %0d, got %0d", want.status, rsp_status);
                  err_count++;
               end
               if (rsp_read_value !== want.rd) begin
                  $error("rsp_read_value: expected %0d, got %0d", want.rd, rsp_read_value);
                  err_count++;
               end
               if (rsp_entry_count !== want.count) begin
                  $error("rsp_entry_count: expected %0d, got %0d", want.count,
                         rsp_entry_count);
                  err_count++;
               end
               n_checked <= n_checked + 1;
            end
         end
         // Receiver stall chance is 87 percent, then 30, then zero.
         idle_pct = (n_checked < phase_len) ? 87 : (n_checked < 2 * phase_len) ? 30 : 0;
         rsp_ready <= ($urandom_range(99) >= idle_pct);
      end
   end

   // Watchdog: ends the run if neither channel moves for too long.
   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

endmodule

// ===== files.f =====
hdl/ilid_pkg.sv
hdl/ilid_cell.sv
hdl/indexed_list_insert_delete.sv
verif/tb_top.sv
